// ===== rtl/core/ffca_pkg.sv =====
`timescale 1ns / 1ps

package ffca_pkg;

	localparam int CELLS_DEFAULT = 64;

	localparam int COUNT_W  = 7;
	localparam int START_W  = 6;
	localparam int STATUS_W = 2;
	localparam int GRANT_W  = 6;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_BAD_COUNT = 2'd1,
		ST_NO_FIT    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_RESP
	} state_t;

	// scan outcome reported by the cell row
	typedef struct packed {
		logic hit;
		logic miss;
	} scan_stat_t;

endpackage

// ===== rtl/core/ffca_req_if.sv =====
`timescale 1ns / 1ps

interface ffca_req_if;
	import ffca_pkg::*;

	logic               valid;
	logic               ready;
	logic               command;
	logic [COUNT_W-1:0] count;
	logic [START_W-1:0] start_cell;

	modport source (output valid, output command, output count, output start_cell,
		input ready);
	modport sink (input valid, input command, input count, input start_cell,
		output ready);

endinterface

// ===== rtl/core/ffca_rsp_if.sv =====
`timescale 1ns / 1ps

interface ffca_rsp_if;
	import ffca_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [GRANT_W-1:0]  granted_cell;

	modport source (output valid, output status, output granted_cell, input ready);
	modport sink (input valid, input status, input granted_cell, output ready);

endinterface

// ===== rtl/core/first_fit_contiguous_allocator.sv =====
`timescale 1ns / 1ps

// First-fit allocator over CELLS cells held in a chain of one-bit cells. An
// allocate sends a scan wave down the chain, one cell per cycle, carrying the
// current free-run length; the first cell where the run reaches count stops
// it. An allocate that fits passes through the scan, apply and result states;
// a failed one or a bad count skips apply, and a free goes straight to apply.
// The scan wave through the cell chain sets the allocate latency. One
// transaction is in flight at a time; a result waits in the output register.
module first_fit_contiguous_allocator #(
	parameter int CELLS = ffca_pkg::CELLS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	ffca_req_if.sink   req,
	ffca_rsp_if.source rsp
);
	import ffca_pkg::*;

	localparam int IW = $clog2(CELLS);
	localparam int AW = (IW + 1 > COUNT_W + 1) ? IW + 1 : COUNT_W + 1;

	state_t state_q, state_nxt;

	logic               cmd_q;
	logic [AW-1:0]      len_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      lim_q;
	status_t            status_q;
	logic [GRANT_W-1:0] grant_q;
	logic               launch_q;

	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [GRANT_W-1:0] rsp_grant_q;

	logic          accept;
	logic          apply;
	logic          set_val;
	logic          rsp_free;
	logic [AW-1:0] req_count;
	logic [AW-1:0] req_start;
	logic          count_bad;
	logic [AW-1:0] hit_end;

	scan_stat_t    scan_stat;
	logic [IW-1:0] hit_idx;

	ffca_row #(
		.CELLS (CELLS),
		.IW    (IW),
		.AW    (AW)
	) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.launch  (launch_q),
		.len     (len_q),
		.apply   (apply),
		.set_val (set_val),
		.lo      (lo_q),
		.lim     (lim_q),
		.stat    (scan_stat),
		.hit_idx (hit_idx)
	);

	assign accept    = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req_count = AW'(req.count);
	assign req_start = AW'(req.start_cell);
	assign count_bad = (req_count == '0) || (req_count > AW'(CELLS));
	assign hit_end   = AW'(hit_idx) + AW'(1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.command == CMD_FREE) begin
						state_nxt = S_APPLY;
					end else if (count_bad) begin
						state_nxt = S_RESP;
					end else begin
						state_nxt = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_stat.hit) begin
					state_nxt = S_APPLY;
				end else if (scan_stat.miss) begin
					state_nxt = S_RESP;
				end
			end
			S_APPLY: state_nxt = S_RESP;
			S_RESP: begin
				if (rsp_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		apply     = (state_q == S_APPLY);
		set_val   = (cmd_q == CMD_ALLOC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			launch_q <= (state_q == S_IDLE) && accept && (req.command == CMD_ALLOC)
				&& !count_bad;
			if (state_q == S_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= req.command;
					len_q <= req_count;
					if (req.command == CMD_FREE) begin
						lo_q     <= req_start;
						lim_q    <= req_start + req_count;
						status_q <= ST_DONE;
						grant_q  <= req.start_cell;
					end else begin
						status_q <= ST_BAD_COUNT;
						grant_q  <= '0;
					end
				end
			end
			S_SCAN: begin
				if (scan_stat.hit) begin
					lo_q     <= hit_end - len_q;
					lim_q    <= hit_end;
					status_q <= ST_DONE;
					grant_q  <= GRANT_W'(hit_end - len_q);
				end else if (scan_stat.miss) begin
					status_q <= ST_NO_FIT;
					grant_q  <= '0;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					rsp_status_q <= status_q;
					rsp_grant_q  <= grant_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.granted_cell = rsp_grant_q;

	a_hit_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(scan_stat.hit && scan_stat.miss))
		else $error("scan reported hit and miss together");

	a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_stat.hit || scan_stat.miss) |-> state_q == S_SCAN)
		else $error("scan outcome outside of scan state");

	a_launch_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> state_q == S_SCAN)
		else $error("scan wave launched outside of scan state");

	a_free_applies: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == CMD_FREE) |=> state_q == S_APPLY)
		else $error("free transaction did not go to apply");

endmodule

// ===== rtl/core/ffca_cell.sv =====
`timescale 1ns / 1ps

module ffca_cell #(
	parameter int AW  = 8,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wave_in,
	input  logic [AW-1:0] run_in,
	input  logic [AW-1:0] len,
	input  logic          apply,
	input  logic          set_val,
	input  logic [AW-1:0] lo,
	input  logic [AW-1:0] lim,
	output logic          wave_out,
	output logic [AW-1:0] run_out,
	output logic          hit
);

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic          used_q;
	logic          wave_q;
	logic          hit_q;
	logic [AW-1:0] run_q;
	logic [AW-1:0] run_nxt;
	logic          hit_now;
	logic          in_range;

	assign run_nxt  = used_q ? '0 : run_in + AW'(1);
	assign hit_now  = wave_in && !used_q && (run_nxt == len);
	assign in_range = (MY_IDX >= lo) && (MY_IDX < lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			wave_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			wave_q <= wave_in && !hit_now;
			hit_q  <= hit_now;
			if (apply && in_range) begin
				used_q <= set_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		run_q <= run_nxt;
	end

	assign wave_out = wave_q;
	assign run_out  = run_q;
	assign hit      = hit_q;

endmodule

// ===== rtl/core/ffca_row.sv =====
`timescale 1ns / 1ps

module ffca_row #(
	parameter int CELLS = 64,
	parameter int IW    = 6,
	parameter int AW    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 launch,
	input  logic [AW-1:0]        len,
	input  logic                 apply,
	input  logic                 set_val,
	input  logic [AW-1:0]        lo,
	input  logic [AW-1:0]        lim,
	output ffca_pkg::scan_stat_t stat,
	output logic [IW-1:0]        hit_idx
);
	import ffca_pkg::*;

	logic          wave [CELLS+1];
	logic [AW-1:0] run  [CELLS+1];
	logic [CELLS-1:0] hit_vec;

	assign wave[0] = launch;
	assign run[0]  = '0;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		ffca_cell #(
			.AW  (AW),
			.IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wave_in  (wave[k]),
			.run_in   (run[k]),
			.len      (len),
			.apply    (apply),
			.set_val  (set_val),
			.lo       (lo),
			.lim      (lim),
			.wave_out (wave[k+1]),
			.run_out  (run[k+1]),
			.hit      (hit_vec[k])
		);
	end

	// at most one cell reports a hit per scan
	always_comb begin
		hit_idx = '0;
		for (int k = 0; k < CELLS; k++) begin
			if (hit_vec[k]) begin
				hit_idx = hit_idx | IW'(k);
			end
		end
	end

	assign stat.hit  = |hit_vec;
	assign stat.miss = wave[CELLS];

	// run[CELLS] is the tail of the chain and feeds nothing
	logic [AW-1:0] run_tail_unused;
	assign run_tail_unused = run[CELLS];

endmodule

// ===== tb/sv/tb_first_fit_contiguous_allocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_contiguous_allocator;
	import ffca_pkg::*;

	localparam int CELLS      = CELLS_DEFAULT;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_WAIT = CELLS + 16;

	class alloc_scoreboard;
		typedef struct {
			status_t              status;
			logic [GRANT_W-1:0]   first_cell;
		} grant_t;

		bit [CELLS-1:0] used_map;
		grant_t         grant_q[$];
		int unsigned    run_start_q[$];
		int unsigned    run_len_q[$];
		int             errors;

		function void note_request(cmd_t cmd, bit [COUNT_W-1:0] count,
				bit [START_W-1:0] start);
			grant_t g;
			int run;
			int first;
			int stop;
			g.status     = ST_DONE;
			g.first_cell = '0;
			if (cmd == CMD_ALLOC) begin
				if (count == 0 || count > CELLS) begin
					g.status = ST_BAD_COUNT;
				end else begin
					run   = 0;
					first = -1;
					for (int i = 0; i < CELLS; i++) begin
						if (used_map[i]) begin
							run = 0;
						end else begin
							run++;
							if (run == count) begin
								first = i + 1 - count;
								break;
							end
						end
					end
					if (first < 0) begin
						g.status = ST_NO_FIT;
					end else begin
						for (int i = first; i < first + count; i++)
							used_map[i] = 1'b1;
						g.first_cell = first[GRANT_W-1:0];
						run_start_q.push_back(first);
						run_len_q.push_back(count);
					end
				end
			end else begin
				stop = start + count;
				if (stop > CELLS)
					stop = CELLS;
				for (int i = start; i < stop; i++)
					used_map[i] = 1'b0;
				g.first_cell = start;
			end
			grant_q.push_back(g);
		endfunction

		function void check_result(logic [STATUS_W-1:0] status,
				logic [GRANT_W-1:0] granted_cell);
			grant_t g;
			if (grant_q.size() == 0) begin
				$error("unexpected result: status %0d granted_cell %0d", status,
					granted_cell);
				errors++;
				return;
			end
			g = grant_q.pop_front();
			if (status !== g.status) begin
				$error("status mismatch: expected %0d, actual %0d", g.status, status);
				errors++;
			end
			if (granted_cell !== g.first_cell) begin
				$error("granted_cell mismatch: expected %0d, actual %0d", g.first_cell,
					granted_cell);
				errors++;
			end
		endfunction

		function int pending();
			return grant_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ffca_req_if req_if ();
	ffca_rsp_if rsp_if ();

	first_fit_contiguous_allocator #(.CELLS(CELLS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	alloc_scoreboard sb = new();

	bit tx_steady;
	bit rx_steady;
	bit rx_long_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// transaction monitor: results first, then the accepted request
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				sb.check_result(rsp_if.status, rsp_if.granted_cell);
			if (req_if.valid && req_if.ready)
				sb.note_request(cmd_t'(req_if.command), req_if.count, req_if.start_cell);
		end
	end

	// result receiver
	initial begin
		int stall;
		rsp_if.ready = 1'b0;
		rx_steady    = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_long_hold) begin
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_long_hold = 1'b0;
			end
			if ($urandom_range(0, 49) == 0)
				rx_steady = ~rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	task automatic send_request(cmd_t cmd, int unsigned count, int unsigned start);
		int gap;
		if ($urandom_range(0, 49) == 0)
			tx_steady = ~tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.command    <= cmd;
		req_if.count      <= count[COUNT_W-1:0];
		req_if.start_cell <= start[START_W-1:0];
		do @(posedge clk); while (!req_if.ready);
	endtask

	// waits past the accepting edge first so the monitor has logged the last request
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic send_random();
		int unsigned sel;
		int unsigned cnt;
		int unsigned idx;
		sel = $urandom_range(0, 99);
		if (sel < 85 && sel >= 50 && sb.run_start_q.size() == 0)
			sel = 0;
		if (sel < 50) begin
			idx = $urandom_range(0, 99);
			if (idx < 85)
				cnt = $urandom_range(1, 8);
			else if (idx < 95)
				cnt = $urandom_range(9, CELLS);
			else if (idx < 97)
				cnt = 0;
			else
				cnt = $urandom_range(CELLS + 1, 127);
			send_request(CMD_ALLOC, cnt, $urandom_range(0, 63));
		end else if (sel < 85) begin
			idx = $urandom_range(0, sb.run_start_q.size() - 1);
			send_request(CMD_FREE, sb.run_len_q[idx], sb.run_start_q[idx]);
			sb.run_start_q.delete(idx);
			sb.run_len_q.delete(idx);
		end else if (sel < 95) begin
			send_request(CMD_FREE, $urandom_range(0, 127), $urandom_range(0, 63));
		end else begin
			send_request(CMD_ALLOC, $urandom_range(0, 127), $urandom_range(0, 63));
		end
	endtask

	initial begin
		tx_steady         = 1'b0;
		rx_long_hold      = 1'b0;
		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.command    = CMD_ALLOC;
		req_if.count      = '0;
		req_if.start_cell = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad counts, full pool, clipped and empty frees, first-fit holes
		send_request(CMD_ALLOC, 0, 0);
		send_request(CMD_ALLOC, 127, 63);
		send_request(CMD_ALLOC, CELLS + 1, 21);
		send_request(CMD_ALLOC, CELLS, 42);
		send_request(CMD_ALLOC, 1, 0);
		send_request(CMD_FREE, 0, 5);
		send_request(CMD_FREE, 127, 63);
		send_request(CMD_ALLOC, 1, 0);
		send_request(CMD_ALLOC, 2, 0);
		send_request(CMD_FREE, CELLS, 0);
		send_request(CMD_FREE, 3, 10);
		send_request(CMD_ALLOC, 10, 0);
		send_request(CMD_ALLOC, 5, 0);
		send_request(CMD_ALLOC, 20, 0);
		send_request(CMD_FREE, 5, 10);
		send_request(CMD_ALLOC, 3, 0);
		send_request(CMD_ALLOC, 6, 0);
		send_request(CMD_ALLOC, 2, 0);
		send_request(CMD_FREE, 85, 42);
		send_request(CMD_FREE, 42, 21);
		send_request(CMD_ALLOC, CELLS, 0);
		send_request(CMD_FREE, CELLS, 0);
		send_request(CMD_ALLOC, CELLS, 0);
		send_request(CMD_FREE, 127, 0);
		drain();
		sb.run_start_q.delete();
		sb.run_len_q.delete();

		for (int n = 0; n < 2000; n++) begin
			if (n == 500) begin
				rx_long_hold = 1'b1;
				tx_steady    = 1'b1;
			end
			if (n == 1000 || n == 1500)
				drain();
			send_random();
		end
		drain();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
